// ----- rtl/rprt_pkg.sv -----
// Package: shared types and codes for the received packet range tracker.
package rprt_pkg;

  localparam int PN_W = 62;
  localparam int IDX_W = 9;

  typedef logic [PN_W-1:0] pn_t;
  typedef logic [1:0] action_t;
  typedef logic [3:0] status_t;

  localparam action_t ACT_RECEIVE = 2'd0;
  localparam action_t ACT_DELETE  = 2'd1;
  localparam action_t ACT_READ    = 2'd2;

  localparam status_t ST_NEW       = 4'd0;
  localparam status_t ST_EXTENDED  = 4'd1;
  localparam status_t ST_MERGED    = 4'd2;
  localparam status_t ST_DUPLICATE = 4'd3;
  localparam status_t ST_BELOW     = 4'd4;
  localparam status_t ST_FLOOR     = 4'd5;
  localparam status_t ST_STALE     = 4'd6;
  localparam status_t ST_READ_OK   = 4'd7;
  localparam status_t ST_BAD_INDEX = 4'd8;

  // Per-cell classification of a received number against one range.
  typedef struct packed {
    logic valid;   // cell holds a range
    logic hit;     // start <= pn <= end
    logic ext_up;  // end + 1 == pn
    logic ext_dn;  // start - 1 == pn, start != 0
    logic above;   // pn > end
    logic below;   // end < pn (for delete)
    logic trim;    // start < pn (for delete)
  } cell_flags_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic shift_up;    // cell i takes neighbor i-1 (insert room)
    logic shift_dn;    // cell i takes neighbor i+1 (remove)
    logic set_end;     // write end at target
    logic set_start;   // write start at target
    logic merge_end;   // target-1 takes end of target
    logic load_new;    // target gets [pn,pn]
  } cell_cmd_t;

endpackage

// ----- rtl/received_packet_range_tracker.sv -----
// Top level: received packet range tracker built as a row of range cells.
//
// Usage: drive in_action, in_packet_number and in_range_index with start
// high; the word is taken at a clock edge where busy is low. One result word
// appears on the out_ ports for one cycle, marked by out_valid, and cannot
// be held off by the receiver.
// After the accepting edge the tracker passes through an evaluate state, in
// which every cell classifies the number and the row applies the update,
// then a done state (out_valid) that presents the result. Receive, read,
// stale delete and unused actions go straight from evaluate to done. An
// insert that overflows the row adds an eviction state that shifts it down.
// Delete-below drops the ranges that lie wholly below the new floor, one at
// a time, and trims the lowest remaining range before the result.
// busy is high from accept until the result cycle ends; the next word is
// taken only after busy falls, so a new word never overlaps the last one.
// Read selects the cell by in_range_index. Reset clears the range
// count and the floor; cell contents are left as they are and are never read
// until written.
module received_packet_range_tracker #(
  parameter int MAX_RANGES = 500
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  rprt_pkg::action_t       in_action,
  input  rprt_pkg::pn_t           in_packet_number,
  input  logic [8:0]              in_range_index,
  output logic                    out_valid,
  output rprt_pkg::status_t       out_status,
  output rprt_pkg::pn_t           out_range_low,
  output rprt_pkg::pn_t           out_range_high,
  output logic [8:0]              out_ranges_held,
  output logic                    out_evicted
);
  import rprt_pkg::*;

  localparam int NC = MAX_RANGES + 1;           // one spare cell for overflow
  localparam int CW = $clog2(NC + 1);
  localparam int PW = (NC > 1) ? $clog2(NC) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DEL   = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  action_t     act_r;
  pn_t         pn_r, floor_r;
  logic [8:0]  idx_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  status_t     status_r, status_nxt;
  logic        ev_r, ev_nxt;
  pn_t         lo_r, lo_nxt, hi_r, hi_nxt;

  cell_flags_t flags [NC];
  pn_t         st_q [NC];
  pn_t         en_q [NC];
  logic [NC-1:0] sh_up, sh_dn, ld_new, set_st, set_en, tk_end;

  // per-cell decisions derived from the flag row
  logic [NC-1:0] v_hit, v_up, v_dn, v_ext, v_above, v_below, v_trim;
  logic        any_hit, any_ext;
  logic [PW-1:0] tgt;       // extended cell
  logic        merge_ok;
  logic        tgt_up;      // extension is upward

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      v_hit[i]   = flags[i].hit;
      v_up[i]    = flags[i].ext_up;
      v_dn[i]    = flags[i].ext_dn;
      v_ext[i]   = flags[i].ext_up || flags[i].ext_dn;
      v_above[i] = flags[i].above;
      v_below[i] = flags[i].below;
      v_trim[i]  = flags[i].trim;
    end
  end

  // Ranges are disjoint and non-touching, so at most two cells can touch pn;
  // scanning upward, the last and highest touching cell wins.
  always_comb begin
    any_hit = |v_hit;
    any_ext = |v_ext;
    tgt     = '0;
    tgt_up  = 1'b0;
    for (int i = 0; i < NC; i++) begin
      if (v_ext[i]) begin
        tgt    = PW'(i);
        tgt_up = v_up[i];
      end
    end
    // merge when pn closes the gap between two neighboring cells
    merge_ok = |(v_dn[NC-1:1] & v_up[NC-2:0]);
  end

  // control path
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    ev_nxt     = ev_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    sh_up = '0; sh_dn = '0; ld_new = '0; set_st = '0; set_en = '0; tk_end = '0;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        lo_nxt = '0;
        hi_nxt = '0;
        ev_nxt = 1'b0;
        case (act_r)
          ACT_RECEIVE: begin
            if (pn_r < floor_r) begin
              status_nxt = ST_BELOW;
            end else if (any_hit) begin
              status_nxt = ST_DUPLICATE;
            end else if (any_ext) begin
              if (merge_ok) begin
                status_nxt = ST_MERGED;
                tk_end[tgt - PW'(1)] = 1'b1;
                for (int i = 0; i < NC - 1; i++)
                  if (PW'(i) >= tgt) sh_dn[i] = 1'b1;
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                status_nxt = ST_EXTENDED;
                if (tgt_up) set_en[tgt] = 1'b1;
                else        set_st[tgt] = 1'b1;
              end
            end else begin
              status_nxt = ST_NEW;
              // above flags form a run from cell 0; the new range goes just past it
              ld_new[0] = !v_above[0];
              for (int i = 1; i < NC; i++) begin
                sh_up[i]  = !v_above[i-1];
                ld_new[i] = v_above[i-1] && !v_above[i];
              end
              cnt_nxt = cnt_r + CW'(1);
              if (cnt_r + CW'(1) > CW'(MAX_RANGES)) state_nxt = S_EVICT;
            end
          end
          ACT_DELETE: begin
            if (pn_r < floor_r) begin
              status_nxt = ST_STALE;
            end else begin
              status_nxt = ST_FLOOR;
              state_nxt  = S_DEL;
            end
          end
          ACT_READ: begin
            status_nxt = ST_BAD_INDEX;
            if (CW'(idx_r) < cnt_r && 32'(idx_r) < NC) begin
              status_nxt = ST_READ_OK;
              lo_nxt = st_q[PW'(idx_r)];
              hi_nxt = en_q[PW'(idx_r)];
            end
          end
          default: status_nxt = ST_BAD_INDEX;
        endcase
      end
      S_EVICT: begin
        for (int i = 0; i < NC - 1; i++) sh_dn[i] = 1'b1;
        cnt_nxt   = cnt_r - CW'(1);
        ev_nxt    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DEL: begin
        // drop the lowest range while it lies wholly below the floor
        if (v_below[0]) begin
          for (int i = 0; i < NC - 1; i++) sh_dn[i] = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          if (v_trim[0]) set_st[0] = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // row of cells, each handing data to its neighbors
  for (genvar g = 0; g < NC; g++) begin : g_cell
    rprt_cell u_cell (
      .clk          (clk),
      .pn           (pn_r),
      .valid        (CW'(g) < cnt_r),
      .up_start     ((g == 0) ? pn_r : st_q[(g == 0) ? 0 : g - 1]),
      .up_end       ((g == 0) ? pn_r : en_q[(g == 0) ? 0 : g - 1]),
      .dn_start     ((g == NC - 1) ? st_q[g] : st_q[(g == NC - 1) ? g : g + 1]),
      .dn_end       ((g == NC - 1) ? en_q[g] : en_q[(g == NC - 1) ? g : g + 1]),
      .do_shift_up  (sh_up[g]),
      .do_shift_dn  (sh_dn[g]),
      .do_load_new  (ld_new[g]),
      .do_set_start (set_st[g]),
      .do_set_end   (set_en[g]),
      .do_take_end  (tk_end[g]),
      .take_end     ((g == NC - 1) ? en_q[g] : en_q[(g == NC - 1) ? g : g + 1]),
      .flags        (flags[g]),
      .start_q      (st_q[g]),
      .end_q        (en_q[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      floor_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_EVAL && act_r == ACT_DELETE && !(pn_r < floor_r)) floor_r <= pn_r;
    end
  end

  // captured word and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      act_r <= in_action;
      pn_r  <= in_packet_number;
      idx_r <= in_range_index;
    end
    status_r <= status_nxt;
    ev_r     <= ev_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_DONE);
  assign out_status      = status_r;
  assign out_range_low   = lo_r;
  assign out_range_high  = hi_r;
  assign out_ranges_held = 9'(cnt_r);
  assign out_evicted     = ev_r;

  // range count never exceeds capacity when a result is shown
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r <= CW'(MAX_RANGES))) else $error("count over capacity");
  // eviction only reported alongside a new range
  a_ev_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_status == ST_NEW)) else $error("bad eviction");
  // result strobe lasts exactly one cycle
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");

endmodule

// ----- rtl/rprt_cell.sv -----
// One range cell: holds one [start,end] pair, compares and shifts locally.
module rprt_cell (
  input  logic                 clk,
  input  rprt_pkg::pn_t        pn,
  input  logic                 valid,
  input  rprt_pkg::pn_t        up_start,    // from lower neighbor (index-1)
  input  rprt_pkg::pn_t        up_end,
  input  rprt_pkg::pn_t        dn_start,    // from upper neighbor (index+1)
  input  rprt_pkg::pn_t        dn_end,
  input  logic                 do_shift_up,
  input  logic                 do_shift_dn,
  input  logic                 do_load_new,
  input  logic                 do_set_start,
  input  logic                 do_set_end,
  input  logic                 do_take_end,
  input  rprt_pkg::pn_t        take_end,
  output rprt_pkg::cell_flags_t flags,
  output rprt_pkg::pn_t        start_q,
  output rprt_pkg::pn_t        end_q
);
  import rprt_pkg::*;

  pn_t start_r, end_r;

  assign start_q = start_r;
  assign end_q   = end_r;

  // local compares against the broadcast number
  always_comb begin
    flags.valid  = valid;
    flags.hit    = valid && (start_r <= pn) && (pn <= end_r);
    // a range ending at the top of the number space is never extended upward
    flags.ext_up = valid && (end_r != '1) && (end_r + pn_t'(1) == pn);
    flags.ext_dn = valid && (start_r != '0) && (start_r - pn_t'(1) == pn);
    flags.above  = valid && (pn > end_r);
    flags.below  = valid && (end_r < pn);
    flags.trim   = valid && (start_r < pn);
  end

  // payload update, no reset needed
  always_ff @(posedge clk) begin
    if (do_shift_up) begin
      start_r <= up_start;
      end_r   <= up_end;
    end else if (do_shift_dn) begin
      start_r <= dn_start;
      end_r   <= dn_end;
    end else if (do_load_new) begin
      start_r <= pn;
      end_r   <= pn;
    end else begin
      if (do_set_start) start_r <= pn;
      if (do_set_end)   end_r   <= pn;
      if (do_take_end)  end_r   <= take_end;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the received packet range tracker: table plus random words.
`timescale 1ns / 100ps

module tb_top;
  import rprt_pkg::*;

  localparam int CAP = 500;
  localparam pn_t PN_MAX = {PN_W{1'b1}};
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    status_t    status;
    pn_t        lo;
    pn_t        hi;
    logic [8:0] held;
    logic       ev;
  } result_t;

  typedef struct {
    action_t    act;
    pn_t        pn;
    logic [8:0] idx;
    bit         typed;
    result_t    res;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  action_t          in_action;
  pn_t              in_packet_number;
  logic [8:0]       in_range_index;
  logic             out_valid;
  status_t          out_status;
  pn_t              out_range_low;
  pn_t              out_range_high;
  logic [8:0]       out_ranges_held;
  logic             out_evicted;

  received_packet_range_tracker dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_packet_number(in_packet_number),
    .in_range_index(in_range_index), .out_valid(out_valid),
    .out_status(out_status), .out_range_low(out_range_low),
    .out_range_high(out_range_high), .out_ranges_held(out_ranges_held),
    .out_evicted(out_evicted)
  );

  // Shadow copy of the range table
  bit [63:0] span_lo[0:CAP];
  bit [63:0] span_hi[0:CAP];
  int        span_cnt;
  bit [63:0] floor_pn;

  result_t   pending_words[$];
  int        err_cnt;
  int        idle_pct;
  longint    cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Open a slot at pos and load [pn,pn]
  function automatic void open_span(int pos, bit [63:0] pn);
    for (int j = span_cnt; j > pos; j--) begin
      span_lo[j] = span_lo[j-1];
      span_hi[j] = span_hi[j-1];
    end
    span_lo[pos] = pn;
    span_hi[pos] = pn;
    span_cnt++;
  endfunction

  // Drop the k lowest ranges
  function automatic void drop_low(int k);
    for (int j = 0; j + k < span_cnt; j++) begin
      span_lo[j] = span_lo[j+k];
      span_hi[j] = span_hi[j+k];
    end
    span_cnt -= k;
  endfunction

  // Receive: duplicate, extend (maybe merge downward) or new range
  function automatic status_t absorb_pn(bit [63:0] pn);
    int        i;
    int        c;
    bit [63:0] s;
    bit [63:0] e;
    bit        ext;
    i = span_cnt;
    while (i > 0) begin
      c = i - 1;
      s = span_lo[c];
      e = span_hi[c];
      ext = 1'b0;
      if (s <= pn && pn <= e) return ST_DUPLICATE;
      if (e + 1 == pn) begin
        span_hi[c] = pn;
        ext = 1'b1;
      end else if (s != 0 && s - 1 == pn) begin
        span_lo[c] = pn;
        ext = 1'b1;
      end
      if (ext) begin
        if (c > 0 && span_hi[c-1] + 1 == span_lo[c]) begin
          span_hi[c-1] = span_hi[c];
          for (int j = c; j + 1 < span_cnt; j++) begin
            span_lo[j] = span_lo[j+1];
            span_hi[j] = span_hi[j+1];
          end
          span_cnt--;
          return ST_MERGED;
        end
        return ST_EXTENDED;
      end
      if (pn > e) begin
        open_span(c + 1, pn);
        return ST_NEW;
      end
      i = c;
    end
    open_span(0, pn);
    return ST_NEW;
  endfunction

  // Predict the result word of one accepted input word
  function automatic result_t track_word(action_t act, pn_t pn_in, logic [8:0] idx);
    result_t   r;
    bit [63:0] pn;
    int        k;
    pn = {2'b00, pn_in};
    r.status = ST_BAD_INDEX;
    r.lo = '0;
    r.hi = '0;
    r.ev = 1'b0;
    case (act)
      ACT_RECEIVE: begin
        if (pn < floor_pn) begin
          r.status = ST_BELOW;
        end else begin
          r.status = absorb_pn(pn);
          if (span_cnt > CAP) begin
            drop_low(1);
            r.ev = 1'b1;
          end
        end
      end
      ACT_DELETE: begin
        if (pn < floor_pn) begin
          r.status = ST_STALE;
        end else begin
          floor_pn = pn;
          k = 0;
          while (k < span_cnt && span_hi[k] < pn) k++;
          drop_low(k);
          if (span_cnt > 0 && span_lo[0] < pn) span_lo[0] = pn;
          r.status = ST_FLOOR;
        end
      end
      ACT_READ: begin
        if (idx < span_cnt) begin
          r.status = ST_READ_OK;
          r.lo = span_lo[idx][PN_W-1:0];
          r.hi = span_hi[idx][PN_W-1:0];
        end
      end
      default: ;
    endcase
    r.held = span_cnt[8:0];
    return r;
  endfunction

  // Present one word, wait for acceptance, queue its expected result
  task automatic send_word(action_t act, pn_t pn, logic [8:0] idx, bit typed,
                           result_t res);
    result_t pred;
    start <= 1'b1;
    in_action <= act;
    in_packet_number <= pn;
    in_range_index <= idx;
    do @(posedge clk); while (busy);
    pred = track_word(act, pn, idx);
    pending_words.push_back(typed ? res : pred);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_action <= action_t'($urandom);
      in_packet_number <= pn_t'({$urandom, $urandom});
      in_range_index <= 9'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // Random word with most numbers in a window just around the floor
  task automatic send_random();
    int      sel;
    pn_t     pn;
    action_t act;
    bit [63:0] base;
    sel = $urandom_range(0, 99);
    base = (floor_pn > 3) ? floor_pn - 3 : 0;
    act = ACT_RECEIVE;
    pn = pn_t'(base + $urandom_range(0, 90));
    if (sel >= 55 && sel < 65) begin
      pn = pn_t'({$urandom, $urandom});
    end else if (sel >= 65 && sel < 77) begin
      act = ACT_DELETE;
      if (floor_pn > 0 && $urandom_range(0, 5) == 0) pn = pn_t'(floor_pn - 1);
      else pn = pn_t'(floor_pn + $urandom_range(0, 6));
    end else if (sel >= 77 && sel < 95) begin
      act = ACT_READ;
    end else if (sel >= 95) begin
      act = 2'd3;
    end
    send_word(act, pn, (sel & 1) ? 9'($urandom_range(0, span_cnt + 2)) : 9'($urandom),
              1'b0, '{default: '0});
  endtask

  // Result monitor
  always @(posedge clk) begin
    result_t x;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        x = pending_words.pop_front();
        if (out_status !== x.status) begin
          $error("status exp %0d got %0d", x.status, out_status);
          err_cnt++;
        end
        if (out_range_low !== x.lo) begin
          $error("range_low exp %0h got %0h", x.lo, out_range_low);
          err_cnt++;
        end
        if (out_range_high !== x.hi) begin
          $error("range_high exp %0h got %0h", x.hi, out_range_high);
          err_cnt++;
        end
        if (out_ranges_held !== x.held) begin
          $error("ranges_held exp %0d got %0d", x.held, out_ranges_held);
          err_cnt++;
        end
        if (out_evicted !== x.ev) begin
          $error("evicted exp %0d got %0d", x.ev, out_evicted);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Directed rows: extremes, every action, floor corner cases
  row_t plan[] = '{
    '{ACT_READ,    62'd0,      9'd0,   1, '{ST_BAD_INDEX, 0, 0, 0, 0}},
    '{ACT_DELETE,  62'd0,      9'd0,   1, '{ST_FLOOR,     0, 0, 0, 0}},
    '{ACT_RECEIVE, 62'd0,      9'd0,   1, '{ST_NEW,       0, 0, 1, 0}},
    '{ACT_RECEIVE, 62'd0,      9'd0,   1, '{ST_DUPLICATE, 0, 0, 1, 0}},
    '{ACT_RECEIVE, 62'd1,      9'd0,   1, '{ST_EXTENDED,  0, 0, 1, 0}},
    '{ACT_RECEIVE, 62'd3,      9'd0,   1, '{ST_NEW,       0, 0, 2, 0}},
    '{ACT_RECEIVE, 62'd2,      9'd0,   1, '{ST_MERGED,    0, 0, 1, 0}},
    '{ACT_READ,    62'd0,      9'd0,   1, '{ST_READ_OK,   0, 3, 1, 0}},
    '{ACT_RECEIVE, PN_MAX,     9'd0,   1, '{ST_NEW,       0, 0, 2, 0}},
    '{ACT_RECEIVE, PN_MAX - 1, 9'd0,   1, '{ST_EXTENDED,  0, 0, 2, 0}},
    '{ACT_READ,    62'd0,      9'd1,   0, '{default: '0}},
    '{ACT_DELETE,  62'd2,      9'd0,   1, '{ST_FLOOR,     0, 0, 2, 0}},
    '{ACT_READ,    62'd0,      9'd0,   1, '{ST_READ_OK,   2, 3, 2, 0}},
    '{ACT_RECEIVE, 62'd1,      9'd0,   1, '{ST_BELOW,     0, 0, 2, 0}},
    '{ACT_DELETE,  62'd1,      9'd0,   1, '{ST_STALE,     0, 0, 2, 0}},
    '{ACT_DELETE,  62'd2,      9'd0,   1, '{ST_FLOOR,     0, 0, 2, 0}},
    '{2'd3,        PN_MAX,     9'd511, 1, '{ST_BAD_INDEX, 0, 0, 2, 0}},
    '{ACT_READ,    62'd0,      9'd2,   1, '{ST_BAD_INDEX, 0, 0, 2, 0}},
    '{ACT_READ,    PN_MAX,     9'd511, 1, '{ST_BAD_INDEX, 0, 0, 2, 0}},
    '{ACT_RECEIVE, 62'd5,      9'd0,   1, '{ST_NEW,       0, 0, 3, 0}},
    '{ACT_DELETE,  62'd5,      9'd0,   1, '{ST_FLOOR,     0, 0, 2, 0}},
    '{ACT_RECEIVE, 62'd4,      9'd0,   1, '{ST_BELOW,     0, 0, 2, 0}},
    '{ACT_RECEIVE, 62'd6,      9'd0,   0, '{default: '0}}
  };

  // Main sequence
  initial begin
    bit [63:0] fill_base;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_RECEIVE;
    in_packet_number = '0;
    in_range_index = '0;
    err_cnt = 0;
    cycle_cnt = 0;
    idle_pct = 0;
    span_cnt = 0;
    floor_pn = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i].act, plan[i].pn, plan[i].idx,
                                plan[i].typed, plan[i].res);

    // Phase 1: back to back random words
    repeat (350) send_random();

    // Hold off until the row has drained
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);

    // Phase 2: fill past capacity with isolated ranges, sender idling
    idle_pct = 54;
    fill_base = floor_pn + 1000;
    for (int i = 0; i < 540; i++) begin
      send_word(ACT_RECEIVE, pn_t'(fill_base + 2 * i), 9'd0, 1'b0, '{default: '0});
      if (i % 40 == 0) send_word(ACT_READ, '0, 9'($urandom_range(0, 511)), 1'b0,
                                 '{default: '0});
    end
    send_word(ACT_READ, '0, 9'd499, 1'b0, '{default: '0});
    send_word(ACT_READ, '0, 9'd500, 1'b0, '{default: '0});
    repeat (100) send_random();
    // Long delete that drops most of the table
    send_word(ACT_DELETE, pn_t'(fill_base + 700), 9'd0, 1'b0, '{default: '0});

    // Phase 3: mixed idling
    idle_pct = 24;
    repeat (350) send_random();

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rprt_pkg.sv
rtl/rprt_cell.sv
rtl/received_packet_range_tracker.sv
dv/tb_top.sv
